[src/napt_pkg.sv]
// ----------------------------------------------------------------------------
// napt_pkg
// Shared constants, codes and types for the NAPT forwarding engine.
// ----------------------------------------------------------------------------
package napt_pkg;

    localparam int MapEntries  = 256;
    localparam int ClientSlots = 16;
    localparam int MapIdxW     = $clog2(MapEntries);
    localparam int MapCntW     = $clog2(MapEntries + 1);
    localparam int CliIdxW     = $clog2(ClientSlots);
    localparam int CliCntW     = $clog2(ClientSlots + 1);

    localparam logic [15:0] DefaultFirstPort = 16'd49152;
    localparam logic [7:0]  ProtoTcp = 8'd6;
    localparam logic [7:0]  ProtoUdp = 8'd17;

    localparam logic [1:0] ActPacket = 2'd0;
    localparam logic [1:0] ActMap    = 2'd1;
    localparam logic [1:0] ActClient = 2'd2;

    localparam logic [3:0] VSame     = 4'd0;
    localparam logic [3:0] VOut      = 4'd1;
    localparam logic [3:0] VIn       = 4'd2;
    localparam logic [3:0] VBadHdr   = 4'd3;
    localparam logic [3:0] VTtl      = 4'd4;
    localparam logic [3:0] VBadXport = 4'd5;
    localparam logic [3:0] VNoMap    = 4'd6;
    localparam logic [3:0] VProto    = 4'd7;
    localparam logic [3:0] VFull     = 4'd8;
    localparam logic [3:0] VLoadOk   = 4'd9;
    localparam logic [3:0] VLoadRej  = 4'd10;

    localparam logic CfgWan  = 1'b0;
    localparam logic CfgPort = 1'b1;

    // compare request to the mapping scan unit
    typedef struct packed {
        logic        start;
        logic [1:0]  mode;   // see ScanLan / ScanWan / ScanRead / ScanAdd
        logic [31:0] addr;
        logic [15:0] lport;
        logic [15:0] wport;
    } t_scan_req;

    typedef struct packed {
        logic               done;
        logic               hit;
        logic [MapIdxW-1:0] idx;
        logic [31:0]        addr;
        logic [15:0]        lport;
        logic [15:0]        wport;
    } t_scan_rsp;

    localparam logic [1:0] ScanLan  = 2'd0;
    localparam logic [1:0] ScanWan  = 2'd1;
    localparam logic [1:0] ScanRead = 2'd2;
    localparam logic [1:0] ScanAdd  = 2'd3;

endpackage

[src/napt_map_scan.sv]
// ----------------------------------------------------------------------------
// napt_map_scan
// Mapping table memory with a one-compare-per-cycle sequential scan unit.
// ----------------------------------------------------------------------------
module napt_map_scan import napt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_scan_req          i_req,
    input  logic [MapCntW-1:0] i_count,
    output t_scan_rsp          o_rsp
);

    logic [63:0] r_mem [MapEntries];
    logic [63:0] r_rd;
    logic        r_busy, n_busy;
    logic        r_rdv;
    logic [1:0]  r_mode;
    logic [31:0] r_addr;
    logic [15:0] r_lport, r_wport;
    logic [MapCntW-1:0] r_ptr, n_ptr;
    logic [MapIdxW-1:0] r_ridx;
    logic        r_done, r_hit;
    logic        match, last, fin;

    // read data and index hold on the entry that ends the scan
    always_ff @(posedge i_clk) begin
        if (i_req.start && i_req.mode == ScanAdd) begin
            r_mem[i_count[MapIdxW-1:0]] <= {i_req.addr, i_req.lport, i_req.wport};
        end
        if (!fin) r_rd <= r_mem[r_ptr[MapIdxW-1:0]];
    end

    assign match = (r_mode == ScanLan) ? (r_rd[63:48] == r_addr[31:16] &&
                   r_rd[47:32] == r_addr[15:0] && r_rd[31:16] == r_lport)
                 : (r_mode == ScanWan) ? (r_rd[15:0] == r_wport) : 1'b1;
    assign last  = (r_ridx == MapIdxW'(i_count - MapCntW'(1)));
    assign fin   = r_busy && r_rdv && (match || last);

    always_comb begin
        n_busy = r_busy;
        n_ptr  = r_ptr;
        if (i_req.start && i_req.mode != ScanAdd) begin
            n_busy = (i_req.mode == ScanRead) || (i_count != '0);
            n_ptr  = (i_req.mode == ScanRead) ? {1'b0, i_req.wport[MapIdxW-1:0]} : '0;
        end else if (fin) begin
            n_busy = 1'b0;
        end else if (r_busy && r_mode != ScanRead) begin
            n_ptr = r_ptr + MapCntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rdv  <= 1'b0;
            r_done <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_rdv  <= r_busy && !(i_req.start) && !fin;
            r_done <= 1'b0;
            if (i_req.start && i_req.mode != ScanAdd && i_req.mode != ScanRead
                && i_count == '0) begin
                r_done <= 1'b1;
                r_hit  <= 1'b0;
            end else if (fin) begin
                r_done <= 1'b1;
                r_hit  <= match;
            end
        end
        if (i_req.start) begin
            r_mode  <= i_req.mode;
            r_addr  <= i_req.addr;
            r_lport <= i_req.lport;
            r_wport <= i_req.wport;
        end
        r_ptr <= n_ptr;
        if (!fin) r_ridx <= r_ptr[MapIdxW-1:0];
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.hit   = r_hit;
    assign o_rsp.idx   = r_ridx;
    assign o_rsp.addr  = r_rd[63:32];
    assign o_rsp.lport = r_rd[31:16];
    assign o_rsp.wport = r_rd[15:0];

endmodule

[src/napt_forwarding_engine.sv]
// ----------------------------------------------------------------------------
// napt_forwarding_engine
// IPv4 NAPT: header checks, subnet test, client and mapping table lookups.
// ----------------------------------------------------------------------------
// One transaction in, one result out. Each item is handled alone: the client
// table is scanned one slot per cycle and the mapping table one entry per
// cycle through a single compare unit on a registered memory read. A header,
// TTL or unused-action item goes straight to its result; a packet that makes
// a new outbound mapping takes the longest path: source client scan, LAN and
// WAN mapping table scans, the table write and the destination client scan.
// s_axis_tready is low while an item is in work or its result waits.
module napt_forwarding_engine import napt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[1:0] src_address[33:2] dst_address[65:34] protocol[73:66]
    // ttl[81:74] src_port[97:82] dst_port[113:98] header_ok[114]
    // transport_ok[115], zero pad to 120
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // verdict[3:0] new_src_address[35:4] new_dst_address[67:36]
    // new_src_port[83:68] new_dst_port[99:84] new_ttl[107:100]
    // to_wan[108], zero pad to 112
    output logic [111:0] m_axis_tdata
);

    localparam logic [3:0] SIdle = 4'd0, SCli1 = 4'd1, SMap1 = 4'd2, SMap2 = 4'd3,
        SCliS = 4'd4, SWait = 4'd5, SCliD = 4'd6, SOut = 4'd7, SRead = 4'd8;

    logic [3:0]  r_st;
    logic [31:0] r_wan;
    logic [16:0] r_next;
    logic [31:0] r_cli [ClientSlots];
    logic [CliCntW-1:0] r_ccnt;
    logic [CliIdxW-1:0] r_ci;
    logic [MapCntW-1:0] r_mcnt;
    logic [1:0]  r_act;
    logic [31:0] r_sa, r_da;
    logic [7:0]  r_proto, r_ttl;
    logic [15:0] r_sp, r_dp;
    logic        r_tok, r_phase, r_hit;
    logic [3:0]  r_v;
    t_scan_req   req;
    t_scan_rsp   rsp;
    logic [31:0] cmp;
    logic        ceq, clast, tcpudp;
    logic [3:0]  ov;

    napt_map_scan u_scan (.i_clk, .i_rst_n, .i_req(req), .i_count(r_mcnt), .o_rsp(rsp));

    assign s_axis_tready = (r_st == SIdle);
    assign o_cfg_ready   = 1'b1;
    assign tcpudp = (r_proto == ProtoTcp) || (r_proto == ProtoUdp);
    assign ceq    = (r_cli[r_ci] == cmp);
    assign clast  = ({1'b0, r_ci} == r_ccnt - CliCntW'(1));

    always_comb begin
        unique case (r_st)
            SCliD:   cmp = r_da;
            default: cmp = r_sa;
        endcase
    end

    always_comb begin
        req = '0;
        req.addr  = r_sa;
        req.lport = r_sp;
        req.wport = r_dp;
        if (r_st == SMap1 && !r_phase) begin
            req.start = 1'b1;
            req.mode  = (r_act == ActMap) ? ScanLan : ((r_hit) ? ScanLan : ScanWan);
        end else if (r_st == SMap2 && !r_phase) begin
            req.start = 1'b1;
            req.mode  = ScanWan;
            req.wport = (r_act == ActMap) ? r_dp : r_next[15:0];
        end else if (r_st == SRead && !r_phase) begin
            req.start = 1'b1;
            req.mode  = ScanAdd;
            req.wport = (r_act == ActMap) ? r_dp : r_next[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= SIdle;
            r_wan   <= '0;
            r_next  <= {1'b0, DefaultFirstPort};
            r_ccnt  <= CliCntW'(1);
            r_mcnt  <= '0;
            r_phase <= 1'b0;
            r_cli[0] <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CfgWan:  r_wan  <= i_cfg_data;
                    CfgPort: r_next <= {1'b0, i_cfg_data[15:0]};
                endcase
            end
            unique case (r_st)
                SIdle: if (s_axis_tvalid) begin
                    r_act   <= s_axis_tdata[1:0];
                    r_sa    <= s_axis_tdata[33:2];
                    r_da    <= s_axis_tdata[65:34];
                    r_proto <= s_axis_tdata[73:66];
                    r_ttl   <= s_axis_tdata[81:74];
                    r_sp    <= s_axis_tdata[97:82];
                    r_dp    <= s_axis_tdata[113:98];
                    r_tok   <= s_axis_tdata[115];
                    r_ci    <= '0;
                    r_phase <= 1'b0;
                    if (s_axis_tdata[1:0] == ActMap) begin
                        r_hit <= 1'b1;
                        if (r_mcnt == MapCntW'(MapEntries)) begin
                            r_v <= VLoadRej; r_st <= SOut;
                        end else r_st <= SMap1;
                    end else if (s_axis_tdata[1:0] == ActClient) begin
                        r_st <= SCli1;
                    end else if (s_axis_tdata[1:0] != ActPacket) begin
                        r_v <= VLoadRej; r_st <= SOut;
                    end else if (!s_axis_tdata[114]) begin
                        r_v <= VBadHdr; r_st <= SOut;
                    end else if (s_axis_tdata[81:74] <= 8'd1) begin
                        r_v <= VTtl; r_st <= SOut;
                    end else begin
                        r_ttl <= s_axis_tdata[81:74] - 8'd1;
                        r_st  <= SCliS;
                    end
                end
                SCli1: begin
                    if (ceq) begin
                        r_v <= VLoadOk; r_st <= SOut;
                    end else if (clast) begin
                        if (r_ccnt == CliCntW'(ClientSlots)) r_v <= VLoadRej;
                        else begin
                            r_cli[r_ccnt[CliIdxW-1:0]] <= r_sa;
                            r_ccnt <= r_ccnt + CliCntW'(1);
                            r_v <= VLoadOk;
                        end
                        r_st <= SOut;
                    end else r_ci <= r_ci + CliIdxW'(1);
                end
                SCliS: begin
                    if (tcpudp && !r_tok) begin
                        r_v <= VBadXport; r_st <= SOut;
                    end else if (r_sa[31:8] == r_da[31:8]) begin
                        r_v <= VSame; r_ci <= '0; r_st <= SCliD;
                    end else if (!tcpudp) begin
                        r_v <= VProto; r_st <= SOut;
                    end else if (ceq || clast) begin
                        r_hit <= ceq;
                        r_st  <= SMap1;
                    end else r_ci <= r_ci + CliIdxW'(1);
                end
                SMap1: begin
                    if (r_phase && rsp.done) begin
                        r_phase <= 1'b0;
                        if (r_act == ActMap) begin
                            if (rsp.hit) begin
                                r_v <= VLoadRej; r_st <= SOut;
                            end else r_st <= SMap2;
                        end else if (!r_hit) begin
                            if (!rsp.hit) begin
                                r_v <= VNoMap; r_st <= SOut;
                            end else begin
                                r_da <= rsp.addr; r_dp <= rsp.lport;
                                r_v <= VIn; r_ci <= '0; r_st <= SCliD;
                            end
                        end else if (rsp.hit) begin
                            r_sa <= r_wan; r_sp <= rsp.wport;
                            r_v <= VOut; r_ci <= '0; r_st <= SCliD;
                        end else if (r_mcnt == MapCntW'(MapEntries) || r_next[16]) begin
                            r_v <= VFull; r_st <= SOut;
                        end else r_st <= SMap2;
                    end else r_phase <= 1'b1;
                end
                SMap2: begin
                    if (r_phase && rsp.done) begin
                        r_phase <= 1'b0;
                        if (rsp.hit) begin
                            if (r_act == ActMap) r_v <= VLoadRej;
                            else begin
                                r_v <= VFull; r_next <= r_next + 17'd1;
                            end
                            r_st <= SOut;
                        end else r_st <= SRead;
                    end else r_phase <= 1'b1;
                end
                SRead: begin
                    r_mcnt <= r_mcnt + MapCntW'(1);
                    if (r_act == ActMap) begin
                        r_v <= VLoadOk; r_st <= SOut;
                    end else begin
                        r_sp <= r_next[15:0];
                        r_sa <= r_wan;
                        r_next <= r_next + 17'd1;
                        r_v <= VOut; r_ci <= '0; r_st <= SCliD;
                    end
                end
                SCliD: begin
                    if (ceq || clast) begin
                        r_hit <= ceq;
                        r_st  <= SWait;
                    end else r_ci <= r_ci + CliIdxW'(1);
                end
                SWait: r_st <= SOut;
                SOut: if (m_axis_tready) r_st <= SIdle;
                default: r_st <= SIdle;
            endcase
        end
    end

    assign ov = r_v;
    assign m_axis_tvalid = (r_st == SOut);
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[3:0] = ov;
        if (ov == VSame || ov == VOut || ov == VIn) begin
            m_axis_tdata[35:4]    = r_sa;
            m_axis_tdata[67:36]   = r_da;
            m_axis_tdata[83:68]   = r_sp;
            m_axis_tdata[99:84]   = r_dp;
            m_axis_tdata[107:100] = r_ttl;
            m_axis_tdata[108]     = !r_hit;
        end
    end

endmodule
